// ----- rtl/rsk_pkg.sv -----
// ---------------------------------------------------------------------------
// rsk_pkg
// shared types for the record sorter: controller states and datapath commands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rsk_pkg;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  typedef struct packed {
    logic insert;
    logic shift;
  } dp_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/rsk_datapath.sv -----
// ---------------------------------------------------------------------------
// rsk_datapath
// row of sorted record cells: ordered insert on load, shift towards the head
// on drain
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsk_datapath import rsk_pkg::*; #(
  parameter int DEPTH    = 32,
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 8,
  parameter int CNT_W    = $clog2(DEPTH + 1)
) (
  input  wire logic                clk,
  input  wire dp_cmd_t             cmd,
  input  wire logic [CNT_W-1:0]    count,
  input  wire logic [KEY_BITS-1:0] in_key,
  input  wire logic [TAG_BITS-1:0] in_tag,
  output logic      [KEY_BITS-1:0] head_key,
  output logic      [TAG_BITS-1:0] head_tag
);

  logic [KEY_BITS-1:0] key_q [DEPTH];
  logic [TAG_BITS-1:0] tag_q [DEPTH];
  logic [DEPTH-1:0]    gt;

  // cells past the fill point, or holding a strictly larger key, make room
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      gt[i] = (CNT_W'(i) >= count) || (key_q[i] > in_key);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd.insert) begin
        if (gt[i]) begin
          if (i == 0) begin
            key_q[i] <= in_key;
            tag_q[i] <= in_tag;
          end else if (!gt[i-1]) begin
            key_q[i] <= in_key;
            tag_q[i] <= in_tag;
          end else begin
            key_q[i] <= key_q[i-1];
            tag_q[i] <= tag_q[i-1];
          end
        end
      end else if (cmd.shift) begin
        if (i < DEPTH - 1) begin
          key_q[i] <= key_q[i+1];
          tag_q[i] <= tag_q[i+1];
        end
      end
    end
  end

  assign head_key = key_q[0];
  assign head_tag = tag_q[0];

endmodule

`default_nettype wire

// ----- rtl/rsk_ctrl.sv -----
// ---------------------------------------------------------------------------
// rsk_ctrl
// load / drain sequencer: fill count, overflow flag and both handshakes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rsk_ctrl import rsk_pkg::*; #(
  parameter int DEPTH = 32,
  parameter int CNT_W = $clog2(DEPTH + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  input  wire logic             s_tlast,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  output logic                  m_tlast,
  output logic                  m_tuser,
  output dp_cmd_t               cmd,
  output logic      [CNT_W-1:0] count
);

  state_t           state, state_next;
  logic [CNT_W-1:0] count_next;
  logic             ovf, ovf_next;

  always_comb begin
    state_next = state;
    count_next = count;
    ovf_next   = ovf;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    m_tlast    = 1'b0;
    unique case (state)
      ST_LOAD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (count < CNT_W'(DEPTH)) begin
            cmd.insert = 1'b1;
            count_next = count + CNT_W'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (s_tlast) begin
            state_next = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        m_tvalid = 1'b1;
        m_tlast  = (count == CNT_W'(1));
        if (m_tready) begin
          cmd.shift  = 1'b1;
          count_next = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            state_next = ST_LOAD;
            ovf_next   = 1'b0;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  assign m_tuser = ovf;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/record_sort_by_key.sv -----
// ---------------------------------------------------------------------------
// record_sort_by_key
// stable ascending sort of a set of keyed records
// ---------------------------------------------------------------------------
// records enter on the s_ stream, one transaction per cycle while loading;
// each is placed at once in key order in a row of DEPTH cells, after any
// record with an equal key, so ties keep arrival order
// a record arriving with the store full is dropped and the overflow flag set
// the transaction with s_tlast closes the set: in the next cycle the sorted
// records stream out on the m_ stream, one per cycle while m_tready is high,
// m_tlast on the final one and m_tuser = overflow on each of them
// s_tready is low while draining; a stall on m_tready simply holds the
// current result and the rest of the set
// reset (rst, synchronous) empties the store and clears the overflow flag
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module record_sort_by_key import rsk_pkg::*; #(
  parameter int DEPTH    = 32,
  parameter int KEY_BITS = 48,
  parameter int TAG_BITS = 8
) (
  input  wire logic                                           clk,
  input  wire logic                                           rst,
  input  wire logic                                           s_tvalid,
  output logic                                                s_tready,
  // income, record_tag, zero pad
  input  wire logic [((KEY_BITS + TAG_BITS + 7) / 8) * 8-1:0] s_tdata,
  input  wire logic                                           s_tlast,  // is_last
  output logic                                                m_tvalid,
  input  wire logic                                           m_tready,
  // out_income, out_tag, zero pad
  output logic      [((KEY_BITS + TAG_BITS + 7) / 8) * 8-1:0] m_tdata,
  output logic                                                m_tlast,  // out_last
  output logic                                                m_tuser   // overflowed
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = ((KEY_BITS + TAG_BITS + 7) / 8) * 8;

  dp_cmd_t             cmd;
  logic [CNT_W-1:0]    count;
  logic [KEY_BITS-1:0] head_key;
  logic [TAG_BITS-1:0] head_tag;

  rsk_ctrl #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .count    (count)
  );

  rsk_datapath #(
    .DEPTH    (DEPTH),
    .KEY_BITS (KEY_BITS),
    .TAG_BITS (TAG_BITS),
    .CNT_W    (CNT_W)
  ) u_datapath (
    .clk      (clk),
    .cmd      (cmd),
    .count    (count),
    .in_key   (s_tdata[KEY_BITS-1:0]),
    .in_tag   (s_tdata[KEY_BITS +: TAG_BITS]),
    .head_key (head_key),
    .head_tag (head_tag)
  );

  assign m_tdata = DATA_W'({head_tag, head_key});

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(m_tvalid && s_tready))
    else $error("load and drain active together");

  a_drain_follows_last: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> m_tvalid)
    else $error("no result after closing transaction");

  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tuser))
    else $error("not reloading after final result");

  a_set_nonempty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (count != '0))
    else $error("drain with empty store");

endmodule

`default_nettype wire
